// ----- src/relief_cell_luminance_unit_defines.svh -----
// Assertion macros for the relief cell luminance unit.
// Depends on nothing; included by the top level.
`ifndef RELIEF_CELL_LUMINANCE_UNIT_DEFINES_SVH
`define RELIEF_CELL_LUMINANCE_UNIT_DEFINES_SVH

// implication in the same cycle
`define RCLU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define RCLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rclu_pkg.sv -----
// Constants, widths and register codes of the relief cell luminance unit.
// Depends on nothing.
`default_nettype none

package rclu_pkg;

    localparam int LANES       = 4;
    localparam int NUM_H       = 5;
    localparam int H_W         = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int SQ_W        = 32;
    localparam int P_W         = 34;
    localparam int C_W         = 35;
    localparam int NUM_W       = 33;
    localparam int R_W         = 35;
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_X_W    = 64;
    localparam int SQRT_REM_W  = 34;
    localparam int RT_W        = 32;
    localparam int DEN_W       = 48;
    localparam int QW          = 54;
    localparam int TERM_W      = 55;
    localparam int SUM_W       = 57;
    localparam int LUM_W       = 40;
    localparam int PIPE_N      = 2 + SQRT_STEPS + 1 + QW + 2;
    localparam int DIV_LAST    = 2 + SQRT_STEPS + 1 + QW - 1;

    localparam logic signed [SUM_W-1:0] LUM_MAX = SUM_W'(64'sd549755813887);
    localparam logic signed [SUM_W-1:0] LUM_MIN = SUM_W'(-64'sd549755813888);

    localparam logic [CFG_W-1:0] SPACING_RESET = 16'd51200;
    localparam logic [CFG_W-1:0] LIGHT_X_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] LIGHT_Y_RESET = 16'd0;
    localparam logic [CFG_W-1:0] LIGHT_Z_RESET = 16'hF333;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACING = 8'd0,
        CFG_LIGHT_X = 8'd1,
        CFG_LIGHT_Y = 8'd2,
        CFG_LIGHT_Z = 8'd3
    } cfg_index_t;

endpackage

`default_nettype wire

// ----- src/relief_cell_luminance_unit.sv -----
// Throughput: one item per cycle while the output is not stalled.
// The length roots run as a 32-stage square root pipeline, one root bit per stage,
// and the reciprocal terms as a 54-stage restoring divider, one quotient bit per stage.
// A stalled output freezes the pipeline; the input register still fills while empty.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
// Depends on rclu_pkg and relief_cell_luminance_unit_defines.svh.
`default_nettype none
`include "relief_cell_luminance_unit_defines.svh"

module relief_cell_luminance_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // height_lower_left, height_lower_right, height_upper_right,
    // height_upper_left, height_center
    input  wire logic [79:0]                 s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // luminance
    output logic [39:0]                      m_tdata,
    // saturated
    output logic [0:0]                       m_tuser,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rclu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rclu_pkg::CFG_W-1:0]  cfg_data
);
    import rclu_pkg::*;

    logic [CFG_W-1:0] spacing_reg, light_x_reg, light_y_reg, light_z_reg;

    logic                 adv;
    logic                 v0_reg;
    logic [PIPE_N-1:0]    vld_reg;
    logic                 out_valid_reg;
    logic [LUM_W-1:0]     lum_reg;
    logic                 sat_reg;

    logic signed [H_W-1:0] h_reg [NUM_H];

    logic [SQ_W-1:0]        sq_reg [LANES], sq_next [LANES];
    logic [SQ_W-1:0]        ssq_reg, ssq_next;
    logic signed [P_W-1:0]  p_reg [6], p_next [6];

    logic [R_W-1:0]         r_reg [LANES], r_next [LANES];
    logic [NUM_W-1:0]       num_reg [LANES], num_next [LANES];
    logic                   neg_reg [LANES], neg_next [LANES];

    logic [SQRT_X_W-1:0]    sx_reg [SQRT_STEPS][LANES], sx_next [SQRT_STEPS][LANES];
    logic [SQRT_REM_W-1:0]  srem_reg [SQRT_STEPS][LANES], srem_next [SQRT_STEPS][LANES];
    logic [RT_W-1:0]        sroot_reg [SQRT_STEPS][LANES], sroot_next [SQRT_STEPS][LANES];
    logic [NUM_W-1:0]       snum_reg [SQRT_STEPS][LANES], snum_next [SQRT_STEPS][LANES];
    logic                   sneg_reg [SQRT_STEPS][LANES], sneg_next [SQRT_STEPS][LANES];

    logic [DEN_W-1:0]       den_reg [LANES], den_next [LANES];
    logic [NUM_W-1:0]       dnum_reg [LANES];
    logic                   dneg_reg [LANES];

    logic [DEN_W-1:0]       qrem_reg [QW][LANES], qrem_next [QW][LANES];
    logic [DEN_W-1:0]       qden_reg [QW][LANES], qden_next [QW][LANES];
    logic [QW-1:0]          qlow_reg [QW][LANES], qlow_next [QW][LANES];
    logic [QW-1:0]          quo_reg [QW][LANES], quo_next [QW][LANES];
    logic                   qneg_reg [QW][LANES], qneg_next [QW][LANES];

    logic signed [TERM_W-1:0] term_reg [LANES], term_next [LANES];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic [CFG_W-1:0]       s_eff;
    logic signed [16:0]     nlx, nly, nlz;
    logic signed [17:0]     sum_a, dif_b;
    logic signed [C_W-1:0]  kz;
    logic signed [C_W-1:0]  c_val [LANES];
    logic signed [16:0]     dif [LANES];
    logic [H_W-1:0]         adif [LANES];
    logic [NUM_W-1:0]       pair_sum [LANES];
    logic [SQRT_X_W-1:0]    sx_in;
    logic [SQRT_REM_W-1:0]  srem_in, sremw, strial;
    logic [RT_W-1:0]        sroot_in;
    logic [DEN_W-1:0]       qrem_in, qden_in;
    logic [QW-1:0]          qlow_in, quo_in;
    logic [DEN_W:0]         qt;
    logic                   qge;
    logic [QW:0]            qplus;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv || !v0_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = lum_reg;
    assign m_tuser   = sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= SPACING_RESET;
            light_x_reg <= LIGHT_X_RESET;
            light_y_reg <= LIGHT_Y_RESET;
            light_z_reg <= LIGHT_Z_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPACING: spacing_reg <= cfg_data;
                CFG_LIGHT_X: light_x_reg <= cfg_data;
                CFG_LIGHT_Y: light_y_reg <= cfg_data;
                CFG_LIGHT_Z: light_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived constants from the registers
    always_comb begin
        s_eff = (spacing_reg == '0) ? CFG_W'(1) : spacing_reg;
        nlx   = -$signed({light_x_reg[CFG_W-1], light_x_reg});
        nly   = -$signed({light_y_reg[CFG_W-1], light_y_reg});
        nlz   = -$signed({light_z_reg[CFG_W-1], light_z_reg});
        sum_a = $signed({nlx[16], nlx}) + $signed({nly[16], nly});
        dif_b = $signed({nly[16], nly}) - $signed({nlx[16], nlx});
        kz    = {{(C_W - 26){nlz[16]}}, nlz, 9'b0};
    end

    // differences, squares and weight products
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            dif[j]     = $signed({h_reg[4][H_W-1], h_reg[4]}) -
                         $signed({h_reg[j][H_W-1], h_reg[j]});
            adif[j]    = dif[j][16] ? H_W'(-dif[j]) : dif[j][H_W-1:0];
            sq_next[j] = adif[j] * adif[j];
        end
        ssq_next  = s_eff * s_eff;
        p_next[0] = sum_a * h_reg[0];
        p_next[1] = dif_b * h_reg[1];
        p_next[2] = nly * h_reg[4];
        p_next[3] = sum_a * h_reg[2];
        p_next[4] = nlx * h_reg[4];
        p_next[5] = dif_b * h_reg[3];
    end

    // root operands and weight magnitudes
    always_comb begin
        c_val[0] = p_reg[0] + p_reg[1] + (p_reg[2] <<< 1) + kz;
        c_val[1] = p_reg[1] - p_reg[3] + (p_reg[4] <<< 1) + kz;
        c_val[2] = -p_reg[3] - p_reg[5] - (p_reg[2] <<< 1) + kz;
        c_val[3] = p_reg[0] - p_reg[5] - (p_reg[4] <<< 1) + kz;
        for (int k = 0; k < LANES; k++) begin
            pair_sum[k] = {1'b0, sq_reg[k]} + {1'b0, sq_reg[(k + 1) % LANES]};
            r_next[k]   = {1'b0, pair_sum[k], 1'b0} + {3'b0, ssq_reg};
            neg_next[k] = c_val[k][C_W-1];
            num_next[k] = c_val[k][C_W-1] ? NUM_W'(-c_val[k]) : c_val[k][NUM_W-1:0];
        end
    end

    // square root pipeline, one root bit per stage
    always_comb begin
        for (int t = 0; t < SQRT_STEPS; t++) begin
            for (int k = 0; k < LANES; k++) begin
                if (t == 0) begin
                    sx_in           = {1'b0, r_reg[k], 28'b0};
                    srem_in         = '0;
                    sroot_in        = '0;
                    snum_next[t][k] = num_reg[k];
                    sneg_next[t][k] = neg_reg[k];
                end else begin
                    sx_in           = sx_reg[t-1][k];
                    srem_in         = srem_reg[t-1][k];
                    sroot_in        = sroot_reg[t-1][k];
                    snum_next[t][k] = snum_reg[t-1][k];
                    sneg_next[t][k] = sneg_reg[t-1][k];
                end
                sremw  = {srem_in[SQRT_REM_W-3:0], sx_in[SQRT_X_W-1:SQRT_X_W-2]};
                strial = {sroot_in, 2'b01};
                if (sremw >= strial) begin
                    srem_next[t][k]  = sremw - strial;
                    sroot_next[t][k] = {sroot_in[RT_W-2:0], 1'b1};
                end else begin
                    srem_next[t][k]  = sremw;
                    sroot_next[t][k] = {sroot_in[RT_W-2:0], 1'b0};
                end
                sx_next[t][k] = {sx_in[SQRT_X_W-3:0], 2'b00};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            den_next[k] = s_eff * sroot_reg[SQRT_STEPS-1][k];
        end
    end

    // restoring divider pipeline, one quotient bit per stage
    always_comb begin
        for (int t = 0; t < QW; t++) begin
            for (int k = 0; k < LANES; k++) begin
                if (t == 0) begin
                    qrem_in         = {36'b0, dnum_reg[k][NUM_W-1:21]};
                    qden_in         = den_reg[k];
                    qlow_in         = {dnum_reg[k][20:0], 33'b0};
                    quo_in          = '0;
                    qneg_next[t][k] = dneg_reg[k];
                end else begin
                    qrem_in         = qrem_reg[t-1][k];
                    qden_in         = qden_reg[t-1][k];
                    qlow_in         = qlow_reg[t-1][k];
                    quo_in          = quo_reg[t-1][k];
                    qneg_next[t][k] = qneg_reg[t-1][k];
                end
                qt  = {qrem_in, qlow_in[QW-1]};
                qge = qt >= {1'b0, qden_in};
                qrem_next[t][k] = qge ? DEN_W'(qt - {1'b0, qden_in}) : qt[DEN_W-1:0];
                quo_next[t][k]  = {quo_in[QW-2:0], qge};
                qlow_next[t][k] = {qlow_in[QW-2:0], 1'b0};
                qden_next[t][k] = qden_in;
            end
        end
    end

    // round, restore sign, sum
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            qplus        = {1'b0, quo_reg[QW-1][k]} + (QW + 1)'(1);
            term_next[k] = qneg_reg[QW-1][k] ? -$signed({1'b0, qplus[QW:1]})
                                             : $signed({1'b0, qplus[QW:1]});
        end
        sum_next = term_reg[0] + term_reg[1] + term_reg[2] + term_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                v0_reg <= s_tvalid;
            end
            if (adv) begin
                vld_reg       <= {vld_reg[PIPE_N-2:0], v0_reg};
                out_valid_reg <= vld_reg[PIPE_N-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            for (int j = 0; j < NUM_H; j++) begin
                h_reg[j] <= $signed(s_tdata[j*H_W +: H_W]);
            end
        end
        if (adv) begin
            sq_reg  <= sq_next;
            ssq_reg <= ssq_next;
            p_reg   <= p_next;
            r_reg   <= r_next;
            num_reg <= num_next;
            neg_reg <= neg_next;
            sx_reg    <= sx_next;
            srem_reg  <= srem_next;
            sroot_reg <= sroot_next;
            snum_reg  <= snum_next;
            sneg_reg  <= sneg_next;
            den_reg   <= den_next;
            dnum_reg  <= snum_reg[SQRT_STEPS-1];
            dneg_reg  <= sneg_reg[SQRT_STEPS-1];
            qrem_reg  <= qrem_next;
            qden_reg  <= qden_next;
            qlow_reg  <= qlow_next;
            quo_reg   <= quo_next;
            qneg_reg  <= qneg_next;
            term_reg  <= term_next;
            sum_reg   <= sum_next;
            if (sum_reg > LUM_MAX) begin
                lum_reg <= LUM_MAX[LUM_W-1:0];
                sat_reg <= 1'b1;
            end else if (sum_reg < LUM_MIN) begin
                lum_reg <= LUM_MIN[LUM_W-1:0];
                sat_reg <= 1'b1;
            end else begin
                lum_reg <= sum_reg[LUM_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    `RCLU_ASSERT_NOW(a_sat_at_limit, aclk, aresetn, out_valid_reg && sat_reg, (lum_reg == LUM_MAX[LUM_W-1:0]) || (lum_reg == LUM_MIN[LUM_W-1:0]), "saturated result not at a range limit")
    `RCLU_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !adv, $stable(vld_reg) && $stable(sum_reg), "pipeline moved during stall")
    `RCLU_ASSERT_NOW(a_div_rem_bound, aclk, aresetn, vld_reg[DIV_LAST], qrem_reg[QW-1][0] < qden_reg[QW-1][0], "divider remainder not below divisor")

endmodule

`default_nettype wire
